// File: rtl/lkxc_pkg.sv
// Shared types and constants for the LCG keystream XOR cipher.
`default_nettype none
package lkxc_pkg;
    localparam int unsigned ModMax = 32'h8000_0000;

    typedef enum logic [2:0] {
        REG_MULT = 3'd0,
        REG_INCR = 3'd1,
        REG_MOD  = 3'd2,
        REG_SEED = 3'd3,
        REG_INV  = 3'd4
    } reg_index_t;

    // Datapath operations.
    typedef enum logic [2:0] {
        OP_STEP_MUL = 3'd0, // prod = state*mult + incr
        OP_POW_R    = 3'd1, // prod = r*b
        OP_POW_B    = 3'd2, // prod = b*b
        OP_GEO      = 3'd3, // prod = (an-1)*inv
        OP_T1       = 3'd4, // prod = an*seed
        OP_T2       = 3'd5, // prod = geo*incr + t1
        OP_INIT     = 3'd6  // prod = mult (reduce base), r = 1 mod m
    } op_t;

    typedef struct packed {
        logic  start;     // load the product and begin reduction
        op_t   op;
        logic  wr_state;  // write the remainder to the generator state
        logic  wr_r;
        logic  wr_b;
        logic  wr_an;
        logic  wr_geo;
        logic  wr_t1;
        logic  init_r;
        logic  emit;      // capture out byte
    } dp_cmd_t;

    typedef struct packed {
        logic red_done;
    } dp_status_t;
endpackage
`default_nettype wire

// File: rtl/lkxc_datapath.sv
// Datapath: config registers, operand registers, multiplier and iterative reducer.
`default_nettype none
module lkxc_datapath (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 cfg_we,
    input  wire logic [2:0]           cfg_index,
    input  wire logic [31:0]          cfg_data,
    input  wire logic [7:0]           data_byte,
    input  wire lkxc_pkg::dp_cmd_t    cmd,
    output lkxc_pkg::dp_status_t      status,
    output logic [7:0]                out_byte
);
    logic [30:0] mult_reg, incr_reg, seed_reg, inv_reg;
    logic [31:0] mod_reg;
    logic [30:0] state_reg, r_reg, b_reg, an_reg, geo_reg, t1_reg;
    logic [63:0] rem_reg, rem_next, rem_mid;
    logic [94:0] dvs_reg, dvs_next, dvs_half;
    logic [5:0]  cnt_reg;
    logic        busy_reg;
    logic [7:0]  byte_reg;
    logic [31:0] m_eff;
    logic [62:0] prod;
    logic [31:0] mm1;
    logic [30:0] an_m1;
    logic [30:0] red_res;

    // fold bytes: 256 is 1 mod 255
    function automatic logic [7:0] mod255(input logic [30:0] x);
        logic [9:0] s1;
        logic [8:0] s2;
        logic [7:0] s3;
        s1 = {2'b00, x[7:0]} + {2'b00, x[15:8]} + {2'b00, x[23:16]} + {3'b000, x[30:24]};
        s2 = {1'b0, s1[7:0]} + {7'd0, s1[9:8]};
        s3 = s2[7:0] + {7'd0, s2[8]};
        return (s3 == 8'hFF) ? 8'd0 : s3;
    endfunction

    always_comb begin
        if (mod_reg < 32'd2)                   m_eff = 32'd2;
        else if (mod_reg > lkxc_pkg::ModMax)   m_eff = lkxc_pkg::ModMax;
        else                                   m_eff = mod_reg;
    end

    assign mm1   = m_eff - 32'd1;
    // an is already reduced; an-1 mod m wraps zero to m-1
    assign an_m1 = (an_reg == 31'd0) ? mm1[30:0] : an_reg - 31'd1;

    always_comb begin
        unique case (cmd.op)
            lkxc_pkg::OP_STEP_MUL: prod = {32'd0, state_reg} * {32'd0, mult_reg}
                                          + {32'd0, incr_reg};
            lkxc_pkg::OP_POW_R:    prod = {32'd0, r_reg} * {32'd0, b_reg};
            lkxc_pkg::OP_POW_B:    prod = {32'd0, b_reg} * {32'd0, b_reg};
            lkxc_pkg::OP_GEO:      prod = {32'd0, an_m1} * {32'd0, inv_reg};
            lkxc_pkg::OP_T1:       prod = {32'd0, an_reg} * {32'd0, seed_reg};
            lkxc_pkg::OP_T2:       prod = {32'd0, geo_reg} * {32'd0, incr_reg}
                                          + {32'd0, t1_reg};
            lkxc_pkg::OP_INIT:     prod = {32'd0, mult_reg};
            default:               prod = '0;
        endcase
    end

    // restoring reduction, two bits a cycle: subtract m shifted left 63..0
    always_comb begin
        rem_next = rem_reg;
        rem_mid  = rem_reg;
        dvs_next = dvs_reg;
        dvs_half = {1'b0, dvs_reg[94:1]};
        if (busy_reg) begin
            if ({31'd0, rem_reg} >= dvs_reg) rem_mid = rem_reg - dvs_reg[63:0];
            rem_next = rem_mid;
            if ({31'd0, rem_mid} >= dvs_half) rem_next = rem_mid - dvs_half[63:0];
            dvs_next = {2'b00, dvs_reg[94:2]};
        end
    end

    assign red_res = rem_next[30:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mult_reg  <= '0;
            incr_reg  <= '0;
            mod_reg   <= lkxc_pkg::ModMax;
            seed_reg  <= '0;
            inv_reg   <= '0;
            state_reg <= '0;
            busy_reg  <= 1'b0;
            cnt_reg   <= '0;
        end else begin
            if (cfg_we) begin
                unique case (cfg_index)
                    lkxc_pkg::REG_MULT: mult_reg <= cfg_data[30:0];
                    lkxc_pkg::REG_INCR: incr_reg <= cfg_data[30:0];
                    lkxc_pkg::REG_MOD:  mod_reg  <= cfg_data;
                    lkxc_pkg::REG_SEED: begin
                        seed_reg  <= cfg_data[30:0];
                        state_reg <= cfg_data[30:0];
                    end
                    lkxc_pkg::REG_INV:  inv_reg  <= cfg_data[30:0];
                    default: ;
                endcase
            end
            if (cmd.start) begin
                rem_reg  <= {1'b0, prod};
                dvs_reg  <= {m_eff, 63'd0};
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                rem_reg <= rem_next;
                dvs_reg <= dvs_next;
                cnt_reg <= cnt_reg + 6'd1;
                if (cnt_reg == 6'd31) busy_reg <= 1'b0;
            end
            if (cmd.wr_state) state_reg <= red_res;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.wr_b)   b_reg   <= red_res;
        if (cmd.init_r) r_reg   <= (m_eff == 32'd1) ? 31'd0 : 31'd1;
        if (cmd.wr_r)   r_reg   <= red_res;
        if (cmd.wr_an)  an_reg  <= r_reg;
        if (cmd.wr_geo) geo_reg <= red_res;
        if (cmd.wr_t1)  t1_reg  <= red_res;
        if (cmd.emit)   byte_reg <= data_byte ^ mod255(state_reg);
    end

    assign status.red_done = busy_reg && (cnt_reg == 6'd31);
    assign out_byte = byte_reg;
endmodule
`default_nettype wire

// File: rtl/lkxc_ctrl.sv
// Controller: sequences step, power and jump-ahead operations.
`default_nettype none
module lkxc_ctrl (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire logic                 s_cmd,
    input  wire logic [31:0]          s_skip_count,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output lkxc_pkg::dp_cmd_t         cmd,
    input  wire lkxc_pkg::dp_status_t status
);
    typedef enum logic [3:0] {
        S_IDLE, S_STEP, S_STEP_WR, S_INIT, S_PR, S_PB, S_GEO, S_T1, S_T2, S_DONE
    } state_t;

    state_t      state_reg;
    logic [31:0] exp_reg;
    logic [5:0]  bit_reg;
    logic        wait_reg;
    logic        mv_reg;

    always_comb begin
        cmd = '0;
        cmd.op = lkxc_pkg::OP_STEP_MUL;
        unique case (state_reg)
            S_STEP:  cmd.op = lkxc_pkg::OP_STEP_MUL;
            S_INIT:  cmd.op = lkxc_pkg::OP_INIT;
            S_PR:    cmd.op = lkxc_pkg::OP_POW_R;
            S_PB:    cmd.op = lkxc_pkg::OP_POW_B;
            S_GEO:   cmd.op = lkxc_pkg::OP_GEO;
            S_T1:    cmd.op = lkxc_pkg::OP_T1;
            S_T2:    cmd.op = lkxc_pkg::OP_T2;
            default: cmd.op = lkxc_pkg::OP_STEP_MUL;
        endcase
        if (!wait_reg && state_reg != S_IDLE && state_reg != S_STEP_WR
            && state_reg != S_DONE) cmd.start = 1'b1;
        if (wait_reg && status.red_done) begin
            unique case (state_reg)
                S_STEP:  cmd.wr_state = 1'b1;
                S_INIT:  begin cmd.wr_b = 1'b1; cmd.init_r = 1'b1; end
                S_PR:    cmd.wr_r = 1'b1;
                S_PB:    cmd.wr_b = 1'b1;
                S_GEO:   cmd.wr_geo = 1'b1;
                S_T1:    cmd.wr_t1 = 1'b1;
                S_T2:    cmd.wr_state = 1'b1;
                default: ;
            endcase
        end
        // hold the new byte until the output register is free
        if (state_reg == S_STEP_WR && (!mv_reg || m_ready)) cmd.emit = 1'b1;
        if (state_reg == S_DONE) cmd.wr_an = 1'b1;
    end

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = mv_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            wait_reg  <= 1'b0;
            mv_reg    <= 1'b0;
            bit_reg   <= '0;
        end else begin
            if (cmd.emit) mv_reg <= 1'b1;
            else if (m_ready) mv_reg <= 1'b0;
            if (cmd.start) wait_reg <= 1'b1;
            if (wait_reg && status.red_done) wait_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE: if (s_valid && s_ready) begin
                    if (!s_cmd) state_reg <= S_STEP;
                    else if (s_skip_count != 32'd0) begin
                        exp_reg   <= s_skip_count;
                        bit_reg   <= '0;
                        state_reg <= S_INIT;
                    end
                end
                S_STEP:    if (wait_reg && status.red_done) state_reg <= S_STEP_WR;
                S_STEP_WR: if (!mv_reg || m_ready) state_reg <= S_IDLE;
                S_INIT:    if (wait_reg && status.red_done)
                               state_reg <= exp_reg[0] ? S_PR : S_PB;
                S_PR:      if (wait_reg && status.red_done) state_reg <= S_PB;
                S_PB:      if (wait_reg && status.red_done) begin
                    // advance to next exponent bit
                    if (bit_reg == 6'd31 || exp_reg[31:1] == 31'd0) state_reg <= S_DONE;
                    else begin
                        exp_reg   <= {1'b0, exp_reg[31:1]};
                        bit_reg   <= bit_reg + 6'd1;
                        state_reg <= exp_reg[1] ? S_PR : S_PB;
                    end
                end
                S_DONE:    state_reg <= S_GEO;
                S_GEO:     if (wait_reg && status.red_done) state_reg <= S_T1;
                S_T1:      if (wait_reg && status.red_done) state_reg <= S_T2;
                S_T2:      if (wait_reg && status.red_done) state_reg <= S_IDLE;
                default:   state_reg <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

// File: rtl/lcg_keystream_xor_cipher.sv
// Top level: LCG keystream XOR byte cipher with jump-ahead.
// Cipher transaction: one multiply and a reduction, then the result byte is registered.
// Skip transaction: one reduction of the base, a square per count bit to the highest
// set bit, a multiply per set bit, then three more; zero count finishes at once.
// One transaction in flight at a time; a new byte waits until a held one is taken.
// Synchronous active-low reset: registers to defaults, modulus 2^31, state 0.
`default_nettype none
module lcg_keystream_xor_cipher (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [31:0] cfg_data,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic        s_cmd,
    input  wire logic [7:0]  s_data_byte,
    input  wire logic [31:0] s_skip_count,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [7:0]       m_out_byte
);
    lkxc_pkg::dp_cmd_t    cmd;
    lkxc_pkg::dp_status_t status;
    logic [7:0]           byte_hold_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) byte_hold_reg <= s_data_byte;
    end

    lkxc_ctrl u_ctrl (
        .aclk, .aresetn, .s_valid, .s_ready, .s_cmd, .s_skip_count,
        .m_valid, .m_ready, .cmd, .status
    );

    lkxc_datapath u_dp (
        .aclk, .aresetn,
        .cfg_we(cfg_valid), .cfg_index, .cfg_data,
        .data_byte(byte_hold_reg), .cmd, .status, .out_byte(m_out_byte)
    );
endmodule
`default_nettype wire

// File: tb/sv/tb_top.sv
// Self-checking testbench for the LCG keystream XOR cipher.
`timescale 1ns / 1ps
module tb_top;
    typedef struct packed {
        logic        cmd;
        logic [7:0]  data_byte;
        logic [31:0] skip_count;
    } cipher_txn_t;

    localparam logic CMD_CIPHER = 1'b0;
    localparam logic CMD_SKIP   = 1'b1;
    localparam int   CycleLimit = 4_000_000;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = '0;
    logic [31:0] cfg_data = '0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic        s_cmd = 1'b0;
    logic [7:0]  s_data_byte = '0;
    logic [31:0] s_skip_count = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [7:0]  m_out_byte;

    lcg_keystream_xor_cipher i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_valid(s_valid), .s_ready(s_ready), .s_cmd(s_cmd),
        .s_data_byte(s_data_byte), .s_skip_count(s_skip_count),
        .m_valid(m_valid), .m_ready(m_ready), .m_out_byte(m_out_byte)
    );

    always #5 aclk = ~aclk;

    // Shadow registers and generator state
    logic [30:0] gen_mult, gen_incr, gen_seed, gen_inv, gen_state;
    logic [31:0] gen_mod;

    cipher_txn_t pending_txns[$];
    logic [7:0]  expected_bytes[$];
    int          err_count = 0;
    int          n_bytes = 0;
    int          n_skips = 0;
    int          n_cfg = 0;
    longint      cycle_count = 0;
    int          gap_left = 0;
    int          stall_left = 0;

    function automatic longint unsigned modulus_in_use();
        if (gen_mod < 2) return 2;
        if (gen_mod > lkxc_pkg::ModMax) return lkxc_pkg::ModMax;
        return gen_mod;
    endfunction

    function automatic logic [30:0] jump_state(logic [31:0] n);
        longint unsigned m, r, b, an, geo, t1, t2;
        m = modulus_in_use();
        r = 1 % m;
        b = gen_mult % m;
        for (int i = 0; i < 32; i++) begin
            if (n[i]) r = (r * b) % m;
            b = (b * b) % m;
        end
        an = r;
        geo = (((an + m - 1) % m) * (gen_inv % m)) % m;
        t1 = (an * (gen_seed % m)) % m;
        t2 = (geo * (gen_incr % m)) % m;
        return 31'((t1 + t2) % m);
    endfunction

    // Update the shadow state; push an expected byte for cipher commands.
    task automatic predict_cipher(cipher_txn_t t);
        longint unsigned m, s;
        m = modulus_in_use();
        if (t.cmd == CMD_CIPHER) begin
            s = (longint'(gen_state) * gen_mult + gen_incr) % m;
            gen_state = 31'(s);
            expected_bytes.push_back(t.data_byte ^ 8'(s % 255));
        end else if (t.skip_count != 0) begin
            gen_state = jump_state(t.skip_count);
        end
    endtask

    task automatic report_mismatch(string what);
        $display("mismatch at cycle %0d: %s", cycle_count, what);
        err_count++;
    endtask

    function automatic int pick_gap();
        if ($urandom_range(0, 3) == 0) return 0;
        if ($urandom_range(0, 9) == 0) return $urandom_range(10, 60);
        return $urandom_range(0, 3);
    endfunction

    // Driver: one transaction on the input channel at a time
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                predict_cipher({s_cmd, s_data_byte, s_skip_count});
                pending_txns.pop_front();
            end
            if (s_valid && !s_ready) begin
                // hold
            end else if (gap_left > 0) begin
                gap_left <= gap_left - 1;
                s_valid <= 1'b0;
            end else if (pending_txns.size() > 0) begin
                cipher_txn_t t;
                t = pending_txns[0];
                s_valid <= 1'b1;
                s_cmd <= t.cmd;
                s_data_byte <= t.data_byte;
                s_skip_count <= t.skip_count;
                gap_left <= pick_gap();
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Monitor and receiver stalls
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (expected_bytes.size() == 0) begin
                    report_mismatch($sformatf("unexpected byte %0h", m_out_byte));
                end else begin
                    logic [7:0] exp_b;
                    exp_b = expected_bytes.pop_front();
                    if (m_out_byte !== exp_b)
                        report_mismatch($sformatf("out_byte %0h, want %0h", m_out_byte, exp_b));
                end
            end
            if (stall_left > 0) begin
                stall_left <= stall_left - 1;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
                if ($urandom_range(0, 7) == 0) stall_left <= pick_gap();
            end
        end
    end

    always @(posedge aclk) begin
        if (cycle_count > CycleLimit) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("tb: failure");
            $finish;
        end
    end

    task automatic write_reg(lkxc_pkg::reg_index_t idx, logic [31:0] value);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            lkxc_pkg::REG_MULT: gen_mult = value[30:0];
            lkxc_pkg::REG_INCR: gen_incr = value[30:0];
            lkxc_pkg::REG_MOD:  gen_mod = value;
            lkxc_pkg::REG_SEED: begin
                gen_seed = value[30:0];
                gen_state = value[30:0];
            end
            lkxc_pkg::REG_INV:  gen_inv = value[30:0];
            default: ;
        endcase
        n_cfg++;
    endtask

    // Out-of-range index: must be ignored
    task automatic write_bad_index();
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= 3'($urandom_range(5, 7));
        cfg_data <= $urandom;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    task automatic queue_cipher(logic [7:0] b);
        pending_txns.push_back({CMD_CIPHER, b, 32'($urandom)});
    endtask

    task automatic queue_skip(logic [31:0] n);
        pending_txns.push_back({CMD_SKIP, 8'($urandom), n});
        n_skips++;
    endtask

    // Wait until the block has drained, then let a skip finish
    task automatic drain();
        while (pending_txns.size() != 0 || s_valid || expected_bytes.size() != 0)
            @(posedge aclk);
        repeat (2300) @(posedge aclk);
    endtask

    task automatic random_txns(int count);
        repeat (count) begin
            if ($urandom_range(0, 9) == 0) begin
                case ($urandom_range(0, 3))
                    0: queue_skip(0);
                    1: queue_skip($urandom);
                    default: queue_skip($urandom_range(1, 300));
                endcase
            end else begin
                queue_cipher(8'($urandom));
                n_bytes++;
            end
        end
    endtask

    task automatic random_config(logic [31:0] modv);
        logic [31:0] mv;
        mv = modv;
        write_reg(lkxc_pkg::REG_MOD, mv);
        write_reg(lkxc_pkg::REG_MULT, $urandom & 32'h7FFF_FFFF);
        write_reg(lkxc_pkg::REG_INCR, $urandom);
        write_reg(lkxc_pkg::REG_INV, $urandom);
        write_reg(lkxc_pkg::REG_SEED, $urandom);
    endtask

    initial begin
        gen_mult = '0; gen_incr = '0; gen_seed = '0; gen_inv = '0; gen_state = '0;
        gen_mod = lkxc_pkg::ModMax;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: reset defaults, then a classic generator
        queue_cipher(8'h00); queue_cipher(8'hFF); queue_skip(0);
        n_bytes += 2;
        drain();
        write_reg(lkxc_pkg::REG_MULT, 32'd1103515245);
        write_reg(lkxc_pkg::REG_INCR, 32'd12345);
        write_reg(lkxc_pkg::REG_INV, 32'h7FFF_FFFF);
        write_reg(lkxc_pkg::REG_SEED, 32'h7FFF_FFFF);
        write_bad_index();
        queue_cipher(8'h00); queue_cipher(8'hFF); queue_cipher(8'hA5);
        queue_skip(1); queue_cipher(8'h5A); queue_skip(32'hFFFF_FFFF);
        queue_cipher(8'h3C); queue_skip(0); queue_cipher(8'hC3);
        queue_skip(32'h8000_0000); queue_cipher(8'h01);
        n_bytes += 7;
        drain();
        // Modulus extremes: below 2, 2, and the 32-bit maximum above 2^31
        write_reg(lkxc_pkg::REG_MOD, 32'd0);
        queue_cipher(8'h80); queue_skip(5); queue_cipher(8'h7F);
        n_bytes += 2;
        drain();
        write_reg(lkxc_pkg::REG_MOD, 32'd2);
        queue_cipher(8'h55); queue_skip(7); queue_cipher(8'hAA);
        n_bytes += 2;
        drain();
        write_reg(lkxc_pkg::REG_MOD, 32'hFFFF_FFFF);
        queue_cipher(8'h11); queue_skip(3); queue_cipher(8'h22);
        n_bytes += 2;
        drain();
        // Multiplier zero gives a^n = 0 on a jump
        write_reg(lkxc_pkg::REG_MOD, 32'd1000);
        write_reg(lkxc_pkg::REG_MULT, 32'd0);
        queue_skip(4); queue_cipher(8'h44);
        n_bytes += 1;
        drain();

        for (int ph = 0; ph < 8; ph++) begin
            case (ph % 4)
                0: random_config(lkxc_pkg::ModMax);
                1: random_config($urandom_range(2, 300));
                2: random_config($urandom);
                default: random_config($urandom & 32'h7FFF_FFFF);
            endcase
            random_txns(100);
            drain();
        end

        $display("covered %0d cipher bytes, %0d jumps, %0d register writes",
                 n_bytes, n_skips, n_cfg);
        if (err_count == 0) begin
            $display("tb: success");
        end else begin
            $display("%0d mismatches", err_count);
            $display("tb: failure");
        end
        $finish;
    end
endmodule
